// File: sv/aupo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aupo_pkg
// Shared constants, register indexes and the queue word type for the ARGB
// unpremultiply, pack and opaque-run block.
// ----------------------------------------------------------------------------
package aupo_pkg;

	localparam int MAX_SIZE   = 1024;
	localparam int CNT_W      = 10;
	localparam int SIZE_W     = 11;
	localparam int LEN_W      = 11;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int PIX_W      = 32;
	localparam int COLOR_W    = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEEP_COLOR      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 2'd2;

	localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE      = 11'd320;
	localparam logic              RST_DEEP_COLOR      = 1'b1;
	localparam logic [CH_W-1:0]   RST_ALPHA_THRESHOLD = 8'd24;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [CH_W-1:0] ALPHA_ZERO   = 8'h00;
	localparam logic [CH_W-1:0] CH_SAT       = 8'hff;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic              run_done;
		logic [CNT_W-1:0]  run_row;
		logic [CNT_W-1:0]  run_first_col;
		logic [LEN_W-1:0]  run_length;
		logic              row_last;
		logic              frame_last;
	} aupo_item_t;

endpackage
`default_nettype wire

// File: sv/aupo_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aupo_front
// Accepts pixel words, tracks the raster position and opaque runs, and pushes
// the pixel with its run report into the queue.
// ----------------------------------------------------------------------------
module aupo_front import aupo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    argb_pixel,
	input  logic [SIZE_W-1:0]   image_size,
	input  logic [CH_W-1:0]     alpha_threshold,
	input  logic                fifo_full,
	output logic                push,
	output aupo_item_t          push_item
);

	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;
	logic              run_open_q;
	logic [CNT_W-1:0]  run_begin_q;

	logic [SIZE_W-1:0] size_c;
	logic [SIZE_W-1:0] size_m1_w;
	logic [CNT_W-1:0]  size_m1;
	logic              last_col;
	logic              last_row;
	logic              opaque;
	logic [CNT_W-1:0]  begin_eff;
	logic [LEN_W-1:0]  span;
	logic              done;
	logic [CNT_W-1:0]  first;
	logic [LEN_W-1:0]  len;
	logic              open_d;
	logic [CNT_W-1:0]  begin_d;

	assign in_ready = !fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		if (image_size == '0) begin
			size_c = SIZE_W'(1);
		end else if (image_size > SIZE_W'(MAX_SIZE)) begin
			size_c = SIZE_W'(MAX_SIZE);
		end else begin
			size_c = image_size;
		end
	end

	assign size_m1_w = size_c - SIZE_W'(1);
	assign size_m1   = size_m1_w[CNT_W-1:0];
	assign last_col  = col_q >= size_m1;
	assign last_row  = row_q >= size_m1;
	assign opaque    = argb_pixel[PIX_W-1 -: CH_W] > alpha_threshold;
	assign begin_eff = run_open_q ? run_begin_q : col_q;
	assign span      = {1'b0, col_q} - {1'b0, begin_eff};

	always_comb begin
		done    = 1'b0;
		first   = '0;
		len     = '0;
		open_d  = run_open_q;
		begin_d = run_begin_q;
		if (opaque) begin
			if (last_col) begin
				done   = 1'b1;
				first  = begin_eff;
				len    = span + LEN_W'(1);
				open_d = 1'b0;
			end else begin
				open_d  = 1'b1;
				begin_d = begin_eff;
			end
		end else if (run_open_q) begin
			done   = 1'b1;
			first  = run_begin_q;
			len    = span;
			open_d = 1'b0;
		end
	end

	always_comb begin
		push_item.pixel         = argb_pixel;
		push_item.run_done      = done;
		push_item.run_row       = done ? row_q : '0;
		push_item.run_first_col = first;
		push_item.run_length    = len;
		push_item.row_last      = last_col;
		push_item.frame_last    = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			run_open_q  <= 1'b0;
			run_begin_q <= '0;
		end else if (push) begin
			run_open_q  <= open_d;
			run_begin_q <= begin_d;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/aupo_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aupo_fifo
// Short queue of classified pixel words between the front and the divider.
// ----------------------------------------------------------------------------
module aupo_fifo import aupo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  aupo_item_t  push_item,
	output logic        full,
	input  logic        pop,
	output aupo_item_t  pop_item,
	output logic        empty
);

	aupo_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW:0]    count_q;

	assign full     = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/aupo_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aupo_back
// Unpremultiplies the three channels with a bit-serial divider, packs the
// color and holds the finished word in the output register.
// ----------------------------------------------------------------------------
module aupo_back import aupo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fifo_empty,
	input  aupo_item_t          pop_item,
	output logic                pop,
	input  logic                deep_color,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COLOR_W-1:0]  packed_color,
	output logic                run_done,
	output logic [CNT_W-1:0]    run_row,
	output logic [CNT_W-1:0]    run_first_col,
	output logic [LEN_W-1:0]    run_length,
	output logic                row_last,
	output logic                frame_last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} back_state_t;

	back_state_t         state_q;
	logic [2:0]          cnt_q;
	aupo_item_t          item_q;
	logic [CH_W-1:0]     rem_q  [NUM_CH];
	logic [CH_W-1:0]     low_q  [NUM_CH];
	logic [CH_W-1:0]     quo_q  [NUM_CH];
	logic                sat_q  [NUM_CH];
	logic                out_valid_q;

	logic [CH_W-1:0]     in_alpha;
	logic [CH_W-1:0]     alpha;
	logic [2*CH_W-1:0]   scaled   [NUM_CH];
	logic [CH_W:0]       trial    [NUM_CH];
	logic                ge       [NUM_CH];
	logic [CH_W:0]       diff     [NUM_CH];
	logic [CH_W-1:0]     ch_val   [NUM_CH];
	logic [COLOR_W-1:0]  color;
	logic                load_out;

	assign pop       = (state_q == ST_IDLE) && !fifo_empty;
	assign load_out  = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	assign in_alpha  = pop_item.pixel[PIX_W-1 -: CH_W];
	assign alpha     = item_q.pixel[PIX_W-1 -: CH_W];
	assign out_valid = out_valid_q;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			scaled[i] = {pop_item.pixel[CH_W*i +: CH_W], {CH_W{1'b0}}}
				- {{CH_W{1'b0}}, pop_item.pixel[CH_W*i +: CH_W]};
			trial[i]  = {rem_q[i], low_q[i][CH_W-1]};
			ge[i]     = trial[i] >= {1'b0, alpha};
			diff[i]   = trial[i] - {1'b0, alpha};
			if (alpha == ALPHA_OPAQUE) begin
				ch_val[i] = item_q.pixel[CH_W*i +: CH_W];
			end else if (sat_q[i]) begin
				ch_val[i] = CH_SAT;
			end else begin
				ch_val[i] = quo_q[i];
			end
		end
	end

	always_comb begin
		if (alpha == ALPHA_ZERO) begin
			color = '0;
		end else if (deep_color) begin
			color = {ch_val[2], ch_val[1], ch_val[0]};
		end else begin
			color = {8'b0, ch_val[2][7:3], ch_val[1][7:2], ch_val[0][7:3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cnt_q <= 3'(CH_W - 1);
						if (in_alpha == ALPHA_ZERO || in_alpha == ALPHA_OPAQUE) begin
							state_q <= ST_HOLD;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_item;
			for (int i = 0; i < NUM_CH; i++) begin
				rem_q[i] <= scaled[i][2*CH_W-1 -: CH_W];
				low_q[i] <= scaled[i][CH_W-1:0];
				quo_q[i] <= '0;
				sat_q[i] <= scaled[i][2*CH_W-1 -: CH_W] >= in_alpha;
			end
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < NUM_CH; i++) begin
				rem_q[i] <= ge[i] ? diff[i][CH_W-1:0] : trial[i][CH_W-1:0];
				low_q[i] <= {low_q[i][CH_W-2:0], 1'b0};
				quo_q[i] <= {quo_q[i][CH_W-2:0], ge[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			packed_color  <= color;
			run_done      <= item_q.run_done;
			run_row       <= item_q.run_row;
			run_first_col <= item_q.run_first_col;
			run_length    <= item_q.run_length;
			row_last      <= item_q.row_last;
			frame_last    <= item_q.frame_last;
		end
	end

endmodule
`default_nettype wire

// File: sv/argb_unpremultiply_pack_and_opaque_runs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// argb_unpremultiply_pack_and_opaque_runs
// Converts premultiplied ARGB pixels to RGB888 or RGB565 and reports the
// opaque runs of each row.
//
//   Channel  Signals                                   Word
//   in       in_valid / in_ready                       argb_pixel
//   out      out_valid / out_ready                     packed_color, run_*,
//                                                      row_last, frame_last
//   cfg      cfg_we, cfg_index, cfg_data               register write
//
// A pixel with alpha 0 or 255 skips the division in the divider stage; any
// other pixel goes through the one-bit-per-cycle division of all three
// channels. The front takes a pixel per cycle until its four-word queue fills.
// Reset clears the raster counters, the run state, the queue and the output valid.
// Either side may stall; the queue and the output register hold their words.
// ----------------------------------------------------------------------------
module argb_unpremultiply_pack_and_opaque_runs import aupo_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PIX_W-1:0]       argb_pixel,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COLOR_W-1:0]     packed_color,
	output logic                   run_done,
	output logic [CNT_W-1:0]       run_row,
	output logic [CNT_W-1:0]       run_first_col,
	output logic [LEN_W-1:0]       run_length,
	output logic                   row_last,
	output logic                   frame_last
);

	logic [SIZE_W-1:0]  image_size_q;
	logic               deep_color_q;
	logic [CH_W-1:0]    alpha_threshold_q;

	logic               push;
	aupo_item_t         push_item;
	logic               fifo_full;
	logic               pop;
	aupo_item_t         pop_item;
	logic               fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q      <= RST_IMAGE_SIZE;
			deep_color_q      <= RST_DEEP_COLOR;
			alpha_threshold_q <= RST_ALPHA_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_SIZE: begin
					image_size_q <= cfg_data;
				end
				CFG_DEEP_COLOR: begin
					deep_color_q <= cfg_data[0];
				end
				CFG_ALPHA_THRESHOLD: begin
					alpha_threshold_q <= cfg_data[CH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	aupo_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.argb_pixel      (argb_pixel),
		.image_size      (image_size_q),
		.alpha_threshold (alpha_threshold_q),
		.fifo_full       (fifo_full),
		.push            (push),
		.push_item       (push_item)
	);

	aupo_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (fifo_empty)
	);

	aupo_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_empty    (fifo_empty),
		.pop_item      (pop_item),
		.pop           (pop),
		.deep_color    (deep_color_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packed_color  (packed_color),
		.run_done      (run_done),
		.run_row       (run_row),
		.run_first_col (run_first_col),
		.run_length    (run_length),
		.row_last      (row_last),
		.frame_last    (frame_last)
	);

endmodule
`default_nettype wire

// File: sv/aupo_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aupo_checker
// Port-level checks for the unpremultiply and opaque-run block.
// ----------------------------------------------------------------------------
module aupo_checker import aupo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [COLOR_W-1:0]  packed_color,
	input  logic                run_done,
	input  logic [CNT_W-1:0]    run_row,
	input  logic [CNT_W-1:0]    run_first_col,
	input  logic [LEN_W-1:0]    run_length,
	input  logic                row_last,
	input  logic                frame_last
);

	// A stalled output word keeps its color.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_color))
		else $error("output word dropped or changed while stalled");

	a_no_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_done |-> run_row == '0 && run_first_col == '0 && run_length == '0)
		else $error("run fields not zero without a finished run");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> row_last)
		else $error("frame end without row end");

	// A finished run holds at least one pixel and ends within MAX_SIZE columns.
	a_run_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_done |-> run_length != '0
			&& ({1'b0, run_first_col} + run_length) <= LEN_W'(MAX_SIZE))
		else $error("finished run outside the row");

endmodule

bind argb_unpremultiply_pack_and_opaque_runs aupo_checker u_aupo_checker (.*);
`default_nettype wire

// File: sim/argb_unpremultiply_pack_and_opaque_runs_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_unpremultiply_pack_and_opaque_runs_tb
// Streams premultiplied ARGB pixels into the block under random stalls on both
// sides and compares every output word against a cycle-free model of the
// color conversion, the RGB888/RGB565 packing and the per-row opaque runs.
// Register settings change between phases, including size changes in the
// middle of a frame and a full-width opaque row at the largest image size.
// ----------------------------------------------------------------------------

typedef struct {
	logic [23:0] color;
	logic        run_done;
	logic [9:0]  run_row;
	logic [9:0]  first_col;
	logic [10:0] run_len;
	logic        row_last;
	logic        frame_last;
} pixel_result_t;

class color_run_scoreboard;
	logic [10:0]   size_reg;
	logic          deep_reg;
	logic [7:0]    thr_reg;
	logic [9:0]    col_cnt;
	logic [9:0]    row_cnt;
	logic [9:0]    run_start;
	logic          run_active;
	pixel_result_t expected_words[$];
	int            errors;
	int            checked;

	function new();
		size_reg   = aupo_pkg::RST_IMAGE_SIZE;
		deep_reg   = aupo_pkg::RST_DEEP_COLOR;
		thr_reg    = aupo_pkg::RST_ALPHA_THRESHOLD;
		col_cnt    = '0;
		row_cnt    = '0;
		run_start  = '0;
		run_active = 1'b0;
		errors     = 0;
		checked    = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [10:0] data);
		case (idx)
			aupo_pkg::CFG_IMAGE_SIZE:      size_reg = data;
			aupo_pkg::CFG_DEEP_COLOR:      deep_reg = data[0];
			aupo_pkg::CFG_ALPHA_THRESHOLD: thr_reg = data[7:0];
			default: ;
		endcase
	endfunction

	function logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
		logic [15:0] q;
		if (a == aupo_pkg::ALPHA_OPAQUE)
			return c;
		q = (16'(c) * 16'd255) / 16'(a);
		return (q > 16'd255) ? aupo_pkg::CH_SAT : q[7:0];
	endfunction

	function void note_pixel(logic [31:0] px);
		logic [7:0]    a, r, g, b;
		int            eff;
		bit            last_col, last_row, opaque;
		pixel_result_t w;
		a = px[31:24];
		r = px[23:16];
		g = px[15:8];
		b = px[7:0];
		eff = int'(size_reg);
		if (eff < 1)
			eff = 1;
		if (eff > aupo_pkg::MAX_SIZE)
			eff = aupo_pkg::MAX_SIZE;
		last_col = int'(col_cnt) >= eff - 1;
		last_row = int'(row_cnt) >= eff - 1;
		w = '{default: '0};
		if (a != aupo_pkg::ALPHA_ZERO) begin
			r = unpremultiply(r, a);
			g = unpremultiply(g, a);
			b = unpremultiply(b, a);
			if (deep_reg)
				w.color = {r, g, b};
			else
				w.color = {8'd0, r[7:3], g[7:2], b[7:3]};
		end
		opaque = a > thr_reg;
		if (opaque) begin
			if (!run_active) begin
				run_active = 1'b1;
				run_start  = col_cnt;
			end
			if (last_col) begin
				w.run_done  = 1'b1;
				w.first_col = run_start;
				w.run_len   = 11'(col_cnt) - 11'(run_start) + 11'd1;
				run_active  = 1'b0;
			end
		end else if (run_active) begin
			w.run_done  = 1'b1;
			w.first_col = run_start;
			w.run_len   = 11'(col_cnt) - 11'(run_start);
			run_active  = 1'b0;
		end
		w.run_row    = w.run_done ? row_cnt : 10'd0;
		w.row_last   = last_col;
		w.frame_last = last_col && last_row;
		expected_words.push_back(w);
		if (last_col) begin
			col_cnt = '0;
			row_cnt = last_row ? 10'd0 : row_cnt + 10'd1;
		end else begin
			col_cnt = col_cnt + 10'd1;
		end
	endfunction

	task report(string what);
		if (errors < 100)
			$display("MISMATCH word %0d: %s", checked, what);
		errors++;
	endtask

	task check_word(pixel_result_t got);
		pixel_result_t want;
		if (expected_words.size() == 0) begin
			report($sformatf("unexpected word, color %h", got.color));
			return;
		end
		want = expected_words.pop_front();
		if (got.color !== want.color)
			report($sformatf("packed_color %h, want %h", got.color, want.color));
		if (got.run_done !== want.run_done)
			report($sformatf("run_done %b, want %b", got.run_done, want.run_done));
		if (got.run_row !== want.run_row)
			report($sformatf("run_row %0d, want %0d", got.run_row, want.run_row));
		if (got.first_col !== want.first_col)
			report($sformatf("run_first_col %0d, want %0d", got.first_col, want.first_col));
		if (got.run_len !== want.run_len)
			report($sformatf("run_length %0d, want %0d", got.run_len, want.run_len));
		if (got.row_last !== want.row_last)
			report($sformatf("row_last %b, want %b", got.row_last, want.row_last));
		if (got.frame_last !== want.frame_last)
			report($sformatf("frame_last %b, want %b", got.frame_last, want.frame_last));
		checked++;
	endtask
endclass

module argb_unpremultiply_pack_and_opaque_runs_tb;
	import aupo_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [PIX_W-1:0]      argb_pixel;
	logic                  out_valid;
	logic                  out_ready;
	logic [COLOR_W-1:0]    packed_color;
	logic                  run_done;
	logic [CNT_W-1:0]      run_row;
	logic [CNT_W-1:0]      run_first_col;
	logic [LEN_W-1:0]      run_length;
	logic                  row_last;
	logic                  frame_last;

	color_run_scoreboard sb;
	pixel_result_t       seen_word;
	int                  send_calm;
	int                  recv_calm;

	logic [31:0] reset_cfg_pixels [14] = '{
		32'h00000000, 32'h00ffffff, 32'hffffffff, 32'hff123456,
		32'h01010101, 32'h01ff00ff, 32'h80804020, 32'h80ff8000,
		32'h18181818, 32'h19191919, 32'h7f7f7f7f, 32'h18000000,
		32'hfefdfcfb, 32'h02010000
	};
	logic [31:0] narrow_pixels [10] = '{
		32'h01000000, 32'hfff8fcf8, 32'h00000000, 32'h80808080,
		32'h40102030, 32'hff070307, 32'hc0c0c0c0, 32'h10ffffff,
		32'h00abcdef, 32'hffffffff
	};

	argb_unpremultiply_pack_and_opaque_runs dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.argb_pixel    (argb_pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packed_color  (packed_color),
		.run_done      (run_done),
		.run_row       (run_row),
		.run_first_col (run_first_col),
		.run_length    (run_length),
		.row_last      (row_last),
		.frame_last    (frame_last)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] channel_for(logic [7:0] a);
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom);
		return 8'($urandom_range(0, int'(a)));
	endfunction

	task automatic send_pixel(logic [31:0] px);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		argb_pixel <= px;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(px);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [10:0] size, logic deep, logic [7:0] thr);
		wait_idle();
		write_reg(CFG_IMAGE_SIZE, size);
		write_reg(CFG_DEEP_COLOR, {10'($urandom), deep});
		write_reg(CFG_ALPHA_THRESHOLD, {3'($urandom), thr});
	endtask

	task automatic random_pixels(int count);
		bit          want_on;
		logic [7:0]  a;
		logic [7:0]  thr;
		logic [31:0] px;
		want_on = 1'($urandom);
		thr = sb.thr_reg;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) == 0)
				want_on = !want_on;
			if ($urandom_range(0, 9) == 0) begin
				px = $urandom;
			end else begin
				if (want_on && thr != 8'hff)
					a = ($urandom_range(0, 4) == 0) ? ALPHA_OPAQUE :
						8'($urandom_range(int'(thr) + 1, 255));
				else if ($urandom_range(0, 3) == 0)
					a = ALPHA_ZERO;
				else
					a = 8'($urandom_range(0, int'(thr)));
				px = {a, channel_for(a), channel_for(a), channel_for(a)};
			end
			send_pixel(px);
		end
	endtask

	task automatic opaque_row(int count);
		logic [7:0] a;
		for (int k = 0; k < count; k++) begin
			a = 8'($urandom_range(1, 255));
			send_pixel({a, channel_for(a), channel_for(a), channel_for(a)});
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_word.color      = packed_color;
			seen_word.run_done   = run_done;
			seen_word.run_row    = run_row;
			seen_word.first_col  = run_first_col;
			seen_word.run_len    = run_length;
			seen_word.row_last   = row_last;
			seen_word.frame_last = frame_last;
			sb.check_word(seen_word);
		end
	end

	initial begin
		int idle;
		int busy;
		out_ready = 1'b0;
		recv_calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			idle = pick_gap(recv_calm);
			if (idle > 0) begin
				out_ready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			busy = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) :
				$urandom_range(1, 6);
			out_ready <= 1'b1;
			repeat (busy) @(posedge clk);
		end
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [10:0] size;
		logic [7:0]  thr;
		sb         = new();
		send_calm  = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		argb_pixel = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_cfg_pixels[i])
			send_pixel(reset_cfg_pixels[i]);
		configure(11'd3, 1'b0, 8'd0);
		foreach (narrow_pixels[i])
			send_pixel(narrow_pixels[i]);

		for (int p = 0; p < 10; p++) begin
			case ($urandom_range(0, 5))
				0:       size = 11'd0;
				1:       size = 11'($urandom_range(1025, 2047));
				default: size = 11'($urandom_range(1, 9));
			endcase
			case ($urandom_range(0, 3))
				0:       thr = 8'd0;
				1:       thr = 8'hff;
				default: thr = 8'($urandom);
			endcase
			configure(size, 1'($urandom), thr);
			random_pixels($urandom_range(40, 70));
		end

		configure(11'd1, 1'b1, 8'd0);
		random_pixels(20);
		configure(11'd2047, 1'b0, 8'd0);
		opaque_row(1024);
		random_pixels(30);
		configure(11'd1024, 1'b1, 8'hff);
		random_pixels(40);
		configure(11'd4, 1'b0, 8'd128);
		random_pixels(60);

		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
